// ===== hw/rtl/sat_pkg.sv =====
// shared types for the subscriber address table
// request and result beats, action and status codes, controller state and
// the command and flag groups between controller and datapath
package sat_pkg;

   typedef enum logic [1:0] {
      ACT_ADD     = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_QUERY   = 2'd2,
      ACT_PUBLISH = 2'd3
   } sat_action_type;

   typedef enum logic [3:0] {
      RS_ADDED      = 4'd0,
      RS_PRESENT    = 4'd1,
      RS_REMOVED    = 4'd2,
      RS_ABSENT     = 4'd3,
      RS_FULL       = 4'd4,
      RS_MEMBER     = 4'd5,
      RS_NOT_MEMBER = 4'd6,
      RS_TARGET     = 4'd7,
      RS_EMPTY      = 4'd8
   } sat_status_type;

   typedef struct packed {
      sat_action_type action;
      logic [63:0]    address;
      logic [7:0]     payload_tag;
      logic [7:0]     payload_length;
   } sat_req_type;

   typedef struct packed {
      sat_status_type status;
      logic [63:0]    target_address;
      logic [7:0]     tag_out;
      logic [7:0]     length_out;
      logic [4:0]     count_after;
      logic           last;
   } sat_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_PUBLISH
   } sat_state_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic scan;
      logic shift_init;
      logic shift;
      logic publish;
      logic finish;
   } sat_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic move_done;
      logic hit;
      logic is_remove;
   } sat_flags_type;

endpackage

// ===== hw/rtl/sat_ctrl.sv =====
// sequencing state machine of the subscriber address table
// depends on sat_pkg; drives sat_dpath through a command group
module sat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sat_pkg::sat_action_type action,
   input  sat_pkg::sat_flags_type flags,
   output logic                   busy,
   output sat_pkg::sat_cmd_type   cmd
);

   sat_pkg::sat_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sat_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != sat_pkg::S_IDLE);
      unique case (state_ff)
         sat_pkg::S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = (action == sat_pkg::ACT_PUBLISH) ? sat_pkg::S_PUBLISH
                                                            : sat_pkg::S_SCAN;
            end
         end
         sat_pkg::S_SCAN: begin
            if (flags.scan_done) begin
               if (flags.is_remove && flags.hit) begin
                  cmd.shift_init = 1'b1;
                  state_in       = sat_pkg::S_SHIFT;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = sat_pkg::S_IDLE;
               end
            end else begin
               cmd.scan = 1'b1;
            end
         end
         sat_pkg::S_SHIFT: begin
            cmd.shift = 1'b1;
            if (flags.move_done) begin
               cmd.finish = 1'b1;
               state_in   = sat_pkg::S_IDLE;
            end
         end
         sat_pkg::S_PUBLISH: begin
            cmd.publish = 1'b1;
            if (flags.move_done) begin
               cmd.finish = 1'b1;
               state_in   = sat_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sat_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/sat_dpath.sv =====
// datapath of the subscriber address table: address store, scan pointer,
// match compare, gap closing and result register; depends on sat_pkg
module sat_dpath #(
   parameter int MAX_SUBSCRIBERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sat_pkg::sat_req_type  req_data,
   input  sat_pkg::sat_cmd_type  cmd,
   output sat_pkg::sat_flags_type flags,
   output logic                  rsp_valid,
   output sat_pkg::sat_rsp_type  rsp_data
);

   localparam int IDX_W = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
   localparam int CNT_W = $clog2(MAX_SUBSCRIBERS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SUBSCRIBERS);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   logic [63:0] store_mem [MAX_SUBSCRIBERS];

   sat_pkg::sat_req_type req_ff, req_in;
   sat_pkg::sat_rsp_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     didx_ff, didx_in;
   logic                 dval_ff, dval_in;
   logic                 hit_ff, hit_in;
   logic [CNT_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [63:0]          data_ff;

   logic                 we;
   logic [IDX_W-1:0]     waddr;
   logic [63:0]          wdata;
   logic [CNT_W-1:0]     shift_dst;
   logic                 match;
   logic                 ptr_lt;
   logic [CNT_W+4:0]     ext_keep, ext_inc, ext_dec;

   assign shift_dst = didx_ff - ONE;
   assign match     = dval_ff && (data_ff == req_ff.address);
   assign ptr_lt    = (ptr_ff < total_ff);
   // counts shown on the result are the low five bits
   assign ext_keep  = {5'd0, total_ff};
   assign ext_inc   = {5'd0, total_ff + ONE};
   assign ext_dec   = {5'd0, total_ff - ONE};

   assign flags.scan_done = hit_ff || (!ptr_lt && !dval_ff);
   assign flags.move_done = !ptr_lt && !dval_ff;
   assign flags.hit       = hit_ff;
   assign flags.is_remove = (req_ff.action == sat_pkg::ACT_REMOVE);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      total_in     = total_ff;
      ptr_in       = ptr_ff;
      didx_in      = didx_ff;
      dval_in      = 1'b0;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      we           = 1'b0;
      waddr        = total_ff[IDX_W-1:0];
      wdata        = req_ff.address;

      if (cmd.latch) begin
         req_in = req_data;
         ptr_in = '0;
         hit_in = 1'b0;
      end

      if (cmd.scan) begin
         if (match) begin
            hit_in     = 1'b1;
            hit_idx_in = didx_ff;
         end
         if (ptr_lt && !match && !hit_ff) begin
            dval_in = 1'b1;
            didx_in = ptr_ff;
            ptr_in  = ptr_ff + ONE;
         end
      end

      if (cmd.shift_init) begin
         ptr_in = hit_idx_ff + ONE;
      end

      // entry i+1 read last cycle is written down to entry i
      if (cmd.shift) begin
         if (ptr_lt) begin
            dval_in = 1'b1;
            didx_in = ptr_ff;
            ptr_in  = ptr_ff + ONE;
         end
         if (dval_ff) begin
            we    = 1'b1;
            waddr = shift_dst[IDX_W-1:0];
            wdata = data_ff;
         end
      end

      if (cmd.publish) begin
         if (ptr_lt) begin
            dval_in = 1'b1;
            didx_in = ptr_ff;
            ptr_in  = ptr_ff + ONE;
         end
         if (dval_ff) begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = sat_pkg::RS_TARGET;
            rsp_in.target_address = data_ff;
            rsp_in.tag_out        = req_ff.payload_tag;
            rsp_in.length_out     = req_ff.payload_length;
            rsp_in.count_after    = ext_keep[4:0];
            rsp_in.last           = ((didx_ff + ONE) == total_ff);
         end
      end

      if (cmd.finish) begin
         rsp_in.target_address = req_ff.address;
         rsp_in.tag_out        = '0;
         rsp_in.length_out     = '0;
         rsp_in.count_after    = ext_keep[4:0];
         rsp_in.last           = 1'b1;
         rsp_valid_in          = 1'b1;
         unique case (req_ff.action)
            sat_pkg::ACT_ADD: begin
               if (hit_ff) begin
                  rsp_in.status = sat_pkg::RS_PRESENT;
               end else if (total_ff >= MAX_CNT) begin
                  rsp_in.status = sat_pkg::RS_FULL;
               end else begin
                  we                 = 1'b1;
                  total_in           = total_ff + ONE;
                  rsp_in.status      = sat_pkg::RS_ADDED;
                  rsp_in.count_after = ext_inc[4:0];
               end
            end
            sat_pkg::ACT_REMOVE: begin
               if (hit_ff) begin
                  total_in           = total_ff - ONE;
                  rsp_in.status      = sat_pkg::RS_REMOVED;
                  rsp_in.count_after = ext_dec[4:0];
               end else begin
                  rsp_in.status = sat_pkg::RS_ABSENT;
               end
            end
            sat_pkg::ACT_QUERY: begin
               rsp_in.status = hit_ff ? sat_pkg::RS_MEMBER : sat_pkg::RS_NOT_MEMBER;
            end
            sat_pkg::ACT_PUBLISH: begin
               // stored entries were already sent beat by beat
               rsp_valid_in      = (total_ff == '0);
               rsp_in.status     = sat_pkg::RS_EMPTY;
               rsp_in.tag_out    = req_ff.payload_tag;
               rsp_in.length_out = req_ff.payload_length;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      data_ff <= store_mem[ptr_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dval_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         dval_ff      <= dval_in;
         hit_ff       <= hit_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      didx_ff    <= didx_in;
      hit_idx_ff <= hit_idx_in;
   end

endmodule

// ===== hw/rtl/subscriber_address_table.sv =====
// top level of the subscriber address table
// depends on sat_pkg, sat_ctrl and sat_dpath
//
// An ordered table of up to MAX_SUBSCRIBERS 64-bit addresses. A request
// beat is taken at a clock edge where start is high and busy is low; busy
// then stays high until the request is done. Add, remove and query give one
// result beat; publish gives one beat per stored address in table order,
// with last set on the final one, or a single "no subscribers" beat when the
// table is empty. Result beats appear on rsp_data for exactly one cycle,
// marked by rsp_valid; the receiver cannot stall them and must take each.
// The table sits in a memory with one read and one write port and is walked
// one entry per clock: an add, query or failed remove scans the stored
// entries up to a match, a publish reads each in turn, and a successful
// remove walks every entry once whatever the entry, since the scan stops
// at the match and closing the gap walks only the entries behind it.
// The table needs no clearing after reset; it reads as empty at once.
module subscriber_address_table #(
   parameter int MAX_SUBSCRIBERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sat_pkg::sat_req_type req_data,
   output logic                 rsp_valid,
   output sat_pkg::sat_rsp_type rsp_data
);

   sat_pkg::sat_cmd_type   cmd;
   sat_pkg::sat_flags_type flags;

   // sequencer: idle, scan for a match, close a gap, fan out on publish
   sat_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .flags  (flags),
      .busy   (busy),
      .cmd    (cmd)
   );

   // store, pointers, compare and the registered result beat
   sat_dpath #(
      .MAX_SUBSCRIBERS(MAX_SUBSCRIBERS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/sat_checker.sv =====
// port level checks for the subscriber address table
// depends on sat_pkg; bound to subscriber_address_table below
module sat_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input sat_pkg::sat_rsp_type rsp_data
);

   // an accepted request holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted request");

   // only publish fan-out beats may come without last
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != sat_pkg::RS_TARGET) |-> rsp_data.last)
      else $error("single result without last");

   // a beat that follows a non-final beat continues the same publish
   a_fanout_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && !$past(rsp_data.last))
         |-> (rsp_data.status == sat_pkg::RS_TARGET && $stable(rsp_data.tag_out)
              && $stable(rsp_data.length_out) && $stable(rsp_data.count_after)))
      else $error("publish fan-out broken");

   // table actions never echo a payload
   a_no_payload_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != sat_pkg::RS_TARGET
                 && rsp_data.status != sat_pkg::RS_EMPTY)
         |-> (rsp_data.tag_out == 8'd0 && rsp_data.length_out == 8'd0))
      else $error("payload echoed on table action");

   // an empty publish reports an empty table
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == sat_pkg::RS_EMPTY) |-> (rsp_data.count_after == 5'd0))
      else $error("no-subscriber beat with nonzero count");

endmodule

bind subscriber_address_table sat_checker u_sat_checker (.*);

// ===== verif/subscriber_address_table_tb.sv =====
// self-checking testbench for the subscriber address table
// depends on sat_pkg and subscriber_address_table; keeps a shadow table to
// predict every result beat and checks each one as it leaves the block
module subscriber_address_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   localparam int POOL_SIZE   = 22;
   // longest request is a remove from a full table
   localparam int SETTLE_CYCLES = 40;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   sat_pkg::sat_req_type req_data;
   logic                 rsp_valid;
   sat_pkg::sat_rsp_type rsp_data;

   subscriber_address_table #(
      .MAX_SUBSCRIBERS(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // shadow copy of the table, updated as each request beat is accepted
   logic [63:0]          shadow_addr [TABLE_DEPTH];
   int                   shadow_count;
   sat_pkg::sat_rsp_type pending_beats[$];
   int                   error_count;
   int                   gap_odds;

   // addresses reused often so adds, removes and queries hit each other
   logic [63:0] address_pool [POOL_SIZE];
   logic [63:0] fill_set [TABLE_DEPTH];

   function automatic int find_slot(logic [63:0] addr);
      int i;
      for (i = 0; i < shadow_count; i++) begin
         if (shadow_addr[i] == addr) return i;
      end
      return -1;
   endfunction

   function automatic void push_beat(sat_pkg::sat_status_type status, logic [63:0] addr,
                                     logic [7:0] tag, logic [7:0] len, logic last);
      sat_pkg::sat_rsp_type beat;
      beat.status         = status;
      beat.target_address = addr;
      beat.tag_out        = tag;
      beat.length_out     = len;
      beat.count_after    = shadow_count[4:0];
      beat.last           = last;
      pending_beats.push_back(beat);
   endfunction

   // works out the result beats of one accepted request and updates the table
   function automatic void predict_table_action(sat_pkg::sat_req_type req);
      int slot;
      int i;
      slot = find_slot(req.address);
      case (req.action)
         sat_pkg::ACT_ADD: begin
            if (slot >= 0) begin
               push_beat(sat_pkg::RS_PRESENT, req.address, 8'd0, 8'd0, 1'b1);
            end else if (shadow_count >= TABLE_DEPTH) begin
               push_beat(sat_pkg::RS_FULL, req.address, 8'd0, 8'd0, 1'b1);
            end else begin
               shadow_addr[shadow_count] = req.address;
               shadow_count++;
               push_beat(sat_pkg::RS_ADDED, req.address, 8'd0, 8'd0, 1'b1);
            end
         end
         sat_pkg::ACT_REMOVE: begin
            if (slot < 0) begin
               push_beat(sat_pkg::RS_ABSENT, req.address, 8'd0, 8'd0, 1'b1);
            end else begin
               // close the gap, later entries keep their order
               for (i = slot; i + 1 < shadow_count; i++) begin
                  shadow_addr[i] = shadow_addr[i + 1];
               end
               shadow_count--;
               push_beat(sat_pkg::RS_REMOVED, req.address, 8'd0, 8'd0, 1'b1);
            end
         end
         sat_pkg::ACT_QUERY: begin
            push_beat((slot >= 0) ? sat_pkg::RS_MEMBER : sat_pkg::RS_NOT_MEMBER,
                      req.address, 8'd0, 8'd0, 1'b1);
         end
         default: begin
            if (shadow_count == 0) begin
               push_beat(sat_pkg::RS_EMPTY, req.address, req.payload_tag,
                         req.payload_length, 1'b1);
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  push_beat(sat_pkg::RS_TARGET, shadow_addr[i], req.payload_tag,
                            req.payload_length, i + 1 == shadow_count);
               end
            end
         end
      endcase
   endfunction

   function automatic void report_mismatch(string field, logic [63:0] want,
                                           logic [63:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      error_count++;
   endfunction

   function automatic void check_beat(sat_pkg::sat_rsp_type want, sat_pkg::sat_rsp_type got);
      if (got.status !== want.status)
         report_mismatch("status", 64'(want.status), 64'(got.status));
      if (got.target_address !== want.target_address)
         report_mismatch("target_address", want.target_address, got.target_address);
      if (got.tag_out !== want.tag_out)
         report_mismatch("tag_out", 64'(want.tag_out), 64'(got.tag_out));
      if (got.length_out !== want.length_out)
         report_mismatch("length_out", 64'(want.length_out), 64'(got.length_out));
      if (got.count_after !== want.count_after)
         report_mismatch("count_after", 64'(want.count_after), 64'(got.count_after));
      if (got.last !== want.last)
         report_mismatch("last", 64'(want.last), 64'(got.last));
   endfunction

   // every result beat is taken at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset) begin
         if ($isunknown(rsp_valid)) begin
            $display("%0t: rsp_valid unknown, expected 0 or 1, actual %b", $time, rsp_valid);
            error_count++;
         end else if (rsp_valid) begin
            if (pending_beats.size() == 0) begin
               $display("%0t: result beat with nothing expected, expected none, actual %p",
                        $time, rsp_data);
               error_count++;
            end else begin
               check_beat(pending_beats.pop_front(), rsp_data);
            end
         end
      end
   end

   task automatic hold_start(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // offers one request beat and waits for the edge that takes it
   task automatic send_item(sat_pkg::sat_action_type action, logic [63:0] addr,
                            logic [7:0] tag, logic [7:0] len);
      sat_pkg::sat_req_type req;
      req.action         = action;
      req.address        = addr;
      req.payload_tag    = tag;
      req.payload_length = len;
      if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
         hold_start($urandom_range(1, 11));
      start    <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy !== 1'b0);
      predict_table_action(req);
   endtask

   // sender holds off until every expected beat has come back
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return address_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 85 && shadow_count > 0) return shadow_addr[$urandom_range(0, shadow_count - 1)];
      return {$urandom, $urandom};
   endfunction

   task automatic random_actions(int items, int add_w, int remove_w, int query_w);
      int n;
      int r;
      sat_pkg::sat_action_type action;
      for (n = 0; n < items; n++) begin
         r = $urandom_range(0, 99);
         if (r < add_w) action = sat_pkg::ACT_ADD;
         else if (r < add_w + remove_w) action = sat_pkg::ACT_REMOVE;
         else if (r < add_w + remove_w + query_w) action = sat_pkg::ACT_QUERY;
         else action = sat_pkg::ACT_PUBLISH;
         send_item(action, pick_address(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end
   endtask

   // empty table: publish gives the single no-subscribers beat, query and remove find nothing
   task automatic test_empty_table();
      send_item(sat_pkg::ACT_PUBLISH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'h00);
      send_item(sat_pkg::ACT_QUERY, 64'h0, 8'h00, 8'hFF);
      send_item(sat_pkg::ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h00);
   endtask

   // extreme addresses, duplicate add, table full, full fan-out
   task automatic test_fill_and_full();
      int i;
      fill_set[0] = 64'h0;
      fill_set[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      for (i = 2; i < TABLE_DEPTH; i++) fill_set[i] = {$urandom, $urandom};
      send_item(sat_pkg::ACT_ADD, fill_set[0], 8'hFF, 8'hFF);
      send_item(sat_pkg::ACT_ADD, fill_set[1], 8'h00, 8'h00);
      send_item(sat_pkg::ACT_ADD, fill_set[0], 8'h00, 8'h00);
      for (i = 2; i < TABLE_DEPTH; i++) send_item(sat_pkg::ACT_ADD, fill_set[i], 8'h00, 8'h00);
      send_item(sat_pkg::ACT_ADD, {$urandom, $urandom}, 8'h00, 8'h00);
      // duplicate check wins over the full check
      send_item(sat_pkg::ACT_ADD, fill_set[1], 8'h00, 8'h00);
      send_item(sat_pkg::ACT_PUBLISH, 64'h0, 8'h00, 8'hFF);
   endtask

   // removes at the front, back and middle keep the order of the rest
   task automatic test_remove_order();
      send_item(sat_pkg::ACT_QUERY, fill_set[1], 8'h00, 8'h00);
      send_item(sat_pkg::ACT_REMOVE, fill_set[0], 8'h00, 8'h00);
      send_item(sat_pkg::ACT_REMOVE, fill_set[TABLE_DEPTH - 1], 8'h00, 8'h00);
      send_item(sat_pkg::ACT_REMOVE, fill_set[7], 8'h00, 8'h00);
      send_item(sat_pkg::ACT_PUBLISH, 64'h5A5A_A5A5_0F0F_F0F0, 8'hA5, 8'h5A);
   endtask

   task automatic test_random_fill();
      gap_odds = 4;
      random_actions(120, 50, 15, 20);
   endtask

   task automatic test_random_churn();
      gap_odds = 3;
      random_actions(122, 30, 30, 20);
   endtask

   task automatic test_random_shrink();
      gap_odds = 6;
      random_actions(100, 15, 55, 15);
   endtask

   // closing stretch with the sender never pausing
   task automatic test_random_streaming();
      gap_odds = 0;
      random_actions(100, 35, 30, 15);
   endtask

   initial begin
      int k;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      shadow_count = 0;
      error_count  = 0;
      gap_odds     = 0;
      address_pool[0] = 64'h0;
      address_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      for (k = 2; k < POOL_SIZE; k++) address_pool[k] = {$urandom, $urandom};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_and_full();
      wait_drained();
      test_remove_order();
      test_random_fill();
      wait_drained();
      test_random_churn();
      test_random_shrink();
      wait_drained();
      test_random_streaming();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_beats.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
